### src/bcae_pkg.sv
// bcae_pkg: shared types, constants and the two-dimensional rule function
// for the cellular automaton engine; no dependencies
`default_nettype none
package bcae_pkg;

  localparam int unsigned MaxCellsDefault = 4096;
  localparam int unsigned WordBits = 64;
  localparam int unsigned MaxWords = 64;

  // neighbourhood codes
  localparam logic [1:0] NbhLine    = 2'd0;
  localparam logic [1:0] NbhVonNeum = 2'd1;
  localparam logic [1:0] NbhMoore   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegRule  = 2'd0;
  localparam logic [1:0] RegNbh   = 2'd1;
  localparam logic [1:0] RegWidth = 2'd2;

  // rule values that select the two-dimensional variants
  localparam logic [7:0] Rule30  = 8'd30;
  localparam logic [7:0] Rule82  = 8'd82;
  localparam logic [7:0] Rule110 = 8'd110;
  localparam logic [7:0] Rule150 = 8'd150;

  typedef struct packed {
    logic [63:0] cell_word;
    logic [6:0]  valid_bits;
    logic        last_word;
    logic [15:0] generations;
  } item_t;

  typedef struct packed {
    logic [63:0] result_word;
    logic        result_last;
  } result_t;

  function automatic logic rule_2d(input logic [7:0] rule, input logic moore,
                                   input logic alive, input logic [3:0] n);
    logic r;
    r = alive;
    case (rule)
      Rule30:  r = moore ? (n == 4'd3 || (alive && n == 4'd2))
                         : (alive ? (n < 4'd2) : (n >= 4'd2));
      Rule82:  r = moore ? (alive ? (n == 4'd2 || n == 4'd3) : (n == 4'd3))
                         : (alive ? (n < 4'd3) : (n == 4'd2));
      Rule110: r = moore ? (alive ? (n < 4'd4) : (n == 4'd3 || n == 4'd6))
                         : (alive ? (n != 4'd4) : (n >= 4'd1));
      Rule150: r = n[0];
      default: r = alive;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/bcae_ram.sv
// bcae_ram: one-bit-wide synchronous grid memory, one write and one read
// port, registered read data; no dependencies
`default_nettype none
module bcae_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic             wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic                  rdata
);

  logic mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/binary_cellular_automaton_engine.sv
// binary_cellular_automaton_engine: loads a cell grid, runs generations over
// two grid memory banks and streams the final grid; uses bcae_pkg, bcae_ram
// load: each word transaction writes up to min(valid_bits, 64) cells, with busy
//   high except while the engine waits for start; run: one grid memory read per
//   neighbour slot of each cell, stopping early at a fixed point; emit: one grid
//   read per result bit, 64 bits per result word; the receiver cannot stall
// synchronous reset clears control, defaults config; grid memories not cleared
`default_nettype none
module binary_cellular_automaton_engine #(
  parameter int unsigned MaxCells = bcae_pkg::MaxCellsDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire bcae_pkg::item_t item,
  output logic                 busy,
  output logic                 result_valid,
  output bcae_pkg::result_t    result,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [12:0]     cfg_data
);

  localparam int unsigned AW = $clog2(MaxCells);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned NW = ((CW > 13) ? CW : 13) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]    state;
  logic [7:0]    rule;
  logic [1:0]    nbh;
  logic [12:0]   row_width;
  logic [CW-1:0] cell_total;
  logic          sel;
  bcae_pkg::item_t item_q;
  logic [6:0]    bit_idx;
  logic [15:0]   gens;

  // run-side issue
  logic          run_issue;
  logic [3:0]    slot;
  logic [CW-1:0] cur_cell;
  logic [12:0]   x;
  // read return
  logic          rv_q;
  logic [3:0]    rslot_q;
  logic          rok_q;
  logic [CW-1:0] ridx_q;
  logic [12:0]   re_q;
  logic          a_q, l_q, r_q, changed;
  logic [3:0]    n_q;
  // emit
  logic          emit_issue;
  logic [12:0]   e;
  logic [12:0]   emit_end;
  logic [63:0]   acc;

  logic [AW-1:0] raddr, waddr;
  logic          we, wdata;
  logic          rd0, rd1, rd0_we, rd1_we, d;

  logic [12:0]   w;
  logic [NW-1:0] i_n, w_n, ct_n, nb_addr;
  logic          nb_ok;
  logic          x_gt0, x_rt, has_up;
  logic [6:0]    cnt;
  logic [3:0]    n_fin;
  logic [2:0]    pat;
  logic          new_bit, chg;
  logic [CW-1:0] words;
  logic [12:0]   end_calc;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign w         = (row_width == 13'd0) ? 13'd1 : row_width;
  assign i_n       = NW'(cur_cell);
  assign w_n       = NW'(w);
  assign ct_n      = NW'(cell_total);
  assign x_gt0     = (x != 13'd0);
  assign x_rt      = ((x + 13'd1) != w);
  assign has_up    = (i_n >= w_n);
  assign cnt       = (item_q.valid_bits > 7'd64) ? 7'd64 : item_q.valid_bits;
  assign d         = sel ? rd1 : rd0;

  assign words    = (cell_total + CW'(63)) >> 6;
  assign end_calc = (words == '0) ? 13'd64 :
                    (words > CW'(bcae_pkg::MaxWords)) ? 13'd4096 : 13'(words << 6);

  // neighbour address and validity per slot
  always_comb begin
    nb_addr = i_n;
    nb_ok   = 1'b0;
    if (slot == 4'd0) begin
      nb_ok = 1'b1;
    end else if (nbh == bcae_pkg::NbhLine) begin
      if (slot == 4'd1) begin
        nb_ok   = 1'b1;
        nb_addr = (cur_cell == '0) ? ct_n - NW'(1) : i_n - NW'(1);
      end else if (slot == 4'd2) begin
        nb_ok   = 1'b1;
        nb_addr = ((i_n + NW'(1)) == ct_n) ? '0 : i_n + NW'(1);
      end
    end else if (nbh == bcae_pkg::NbhVonNeum || nbh == bcae_pkg::NbhMoore) begin
      case (slot)
        4'd1: begin nb_addr = i_n - NW'(1);       nb_ok = x_gt0; end
        4'd2: begin nb_addr = i_n + NW'(1);       nb_ok = x_rt; end
        4'd3: begin nb_addr = i_n - w_n;          nb_ok = has_up; end
        4'd4: begin nb_addr = i_n + w_n;          nb_ok = 1'b1; end
        4'd5: begin nb_addr = i_n - w_n - NW'(1); nb_ok = has_up && x_gt0; end
        4'd6: begin nb_addr = i_n - w_n + NW'(1); nb_ok = has_up && x_rt; end
        4'd7: begin nb_addr = i_n + w_n - NW'(1); nb_ok = x_gt0; end
        4'd8: begin nb_addr = i_n + w_n + NW'(1); nb_ok = x_rt; end
        default: begin nb_addr = i_n; nb_ok = 1'b0; end
      endcase
      if (slot >= 4'd5 && nbh != bcae_pkg::NbhMoore) begin
        nb_ok = 1'b0;
      end
      // cells at or past the loaded count read as dead
      if (nb_addr >= ct_n) begin
        nb_ok = 1'b0;
      end
    end
  end

  assign raddr = (state == S_EMIT) ? AW'(e) : AW'(nb_addr);

  // next state of the cell whose last neighbour is returning
  assign n_fin   = n_q + {3'd0, rok_q & d};
  assign pat     = {l_q, a_q, r_q};
  always_comb begin
    if (nbh == bcae_pkg::NbhLine) begin
      new_bit = rule[pat];
    end else if (nbh == bcae_pkg::NbhVonNeum || nbh == bcae_pkg::NbhMoore) begin
      new_bit = bcae_pkg::rule_2d(rule, nbh == bcae_pkg::NbhMoore, a_q, n_fin);
    end else begin
      new_bit = a_q;
    end
  end
  assign chg = changed | (new_bit ^ a_q);

  // memory writes: loading fills the current bank, a sweep fills the other
  always_comb begin
    we    = 1'b0;
    wdata = 1'b0;
    waddr = AW'(cell_total);
    if (state == S_LOAD && bit_idx < cnt && cell_total < CW'(MaxCells)) begin
      we    = 1'b1;
      wdata = item_q.cell_word[bit_idx[5:0]];
    end else if (state == S_RUN && rv_q && rslot_q == 4'd8) begin
      we    = 1'b1;
      wdata = new_bit;
      waddr = AW'(ridx_q);
    end
  end
  assign rd0_we = we && ((state == S_LOAD) ? !sel : sel);
  assign rd1_we = we && ((state == S_LOAD) ? sel : !sel);

  bcae_ram #(.Depth(MaxCells), .AddrW(AW)) u_bank0 (
    .clk(clk), .we(rd0_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
  );
  bcae_ram #(.Depth(MaxCells), .AddrW(AW)) u_bank1 (
    .clk(clk), .we(rd1_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rule         <= 8'd30;
      nbh          <= bcae_pkg::NbhLine;
      row_width    <= 13'd64;
      cell_total   <= '0;
      sel          <= 1'b0;
      run_issue    <= 1'b0;
      emit_issue   <= 1'b0;
      rv_q         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rv_q         <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          bcae_pkg::RegRule:  rule      <= cfg_data[7:0];
          bcae_pkg::RegNbh:   nbh       <= cfg_data[1:0];
          bcae_pkg::RegWidth: row_width <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item_q  <= item;
            bit_idx <= '0;
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (bit_idx < cnt) begin
            bit_idx <= bit_idx + 7'd1;
            if (cell_total < CW'(MaxCells)) begin
              cell_total <= cell_total + CW'(1);
            end
          end else if (!item_q.last_word) begin
            state <= S_IDLE;
          end else if (item_q.generations == 16'd0 || cell_total == '0) begin
            state      <= S_EMIT;
            e          <= '0;
            emit_end   <= end_calc;
            emit_issue <= 1'b1;
          end else begin
            state     <= S_RUN;
            gens      <= item_q.generations;
            run_issue <= 1'b1;
            slot      <= '0;
            cur_cell  <= '0;
            x         <= '0;
            changed   <= 1'b0;
          end
        end
        S_RUN: begin
          if (run_issue) begin
            rv_q    <= 1'b1;
            rslot_q <= slot;
            rok_q   <= nb_ok;
            ridx_q  <= cur_cell;
            if (slot == 4'd8) begin
              slot <= '0;
              if ((cur_cell + CW'(1)) == cell_total) begin
                run_issue <= 1'b0;
              end else begin
                cur_cell <= cur_cell + CW'(1);
                x        <= x_rt ? x + 13'd1 : 13'd0;
              end
            end else begin
              slot <= slot + 4'd1;
            end
          end
          if (rv_q) begin
            case (rslot_q)
              4'd0: begin a_q <= d; n_q <= '0; l_q <= 1'b0; r_q <= 1'b0; end
              4'd1: begin l_q <= rok_q & d; n_q <= n_q + {3'd0, rok_q & d}; end
              4'd2: begin r_q <= rok_q & d; n_q <= n_q + {3'd0, rok_q & d}; end
              4'd8: begin
                changed <= chg;
                if ((ridx_q + CW'(1)) == cell_total) begin
                  gens    <= gens - 16'd1;
                  changed <= 1'b0;
                  if (chg) begin
                    sel <= ~sel;
                  end
                  if (!chg || gens == 16'd1) begin
                    state      <= S_EMIT;
                    e          <= '0;
                    emit_end   <= end_calc;
                    emit_issue <= 1'b1;
                  end else begin
                    run_issue <= 1'b1;
                    slot      <= '0;
                    cur_cell  <= '0;
                    x         <= '0;
                  end
                end
              end
              default: n_q <= n_q + {3'd0, rok_q & d};
            endcase
          end
        end
        S_EMIT: begin
          if (emit_issue) begin
            rv_q <= 1'b1;
            re_q <= e;
            e    <= e + 13'd1;
            if ((e + 13'd1) == emit_end) begin
              emit_issue <= 1'b0;
            end
          end
          if (rv_q) begin
            acc[re_q[5:0]] <= d && (CW'(re_q) < cell_total) && ({1'b0, re_q} < 14'(MaxCells));
            if (re_q[5:0] == 6'd63) begin
              result_valid       <= 1'b1;
              result.result_word <= {d && (CW'(re_q) < cell_total), acc[62:0]};
              result.result_last <= ((re_q + 13'd1) == emit_end);
              if ((re_q + 13'd1) == emit_end) begin
                state      <= S_IDLE;
                cell_total <= '0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    cell_total <= CW'(MaxCells)) else $error("cell count beyond grid size");
  a_last_then_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_last |=> !result_valid)
    else $error("result after final word");
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> slot <= 4'd8) else $error("neighbour slot out of range");
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.result_last |-> busy) else $error("result while idle");
`endif

endmodule
`default_nettype wire
